// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the point vector buffer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk, switched off while rst_n is low.
`define PVB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Implication form of the check above.
`define PVB_ASSERT_IMP(name, ante, cons, msg) \
  `PVB_ASSERT(name, (ante) |-> (cons), msg)

`endif

// ===== hdl/pvb_pkg.sv =====
// Types and constants shared by the point vector buffer modules.
`timescale 1ns / 1ps

package pvb_pkg;

  localparam int CMD_W = 3;
  localparam int IDX_W = 9;
  localparam int CRD_W = 32;
  localparam int STS_W = 2;
  localparam int CNT_W = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_GET    = 3'd2,
    CMD_SET    = 3'd3,
    CMD_INSERT = 3'd4,
    CMD_REMOVE = 3'd5,
    CMD_LENGTH = 3'd6,
    CMD_CLEAR  = 3'd7
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BOUNDS = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_FINISH,
    S_RESP
  } state_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_COMMIT,
    DP_SHIFT_INIT,
    DP_SHIFT,
    DP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic need_shift;
    logic shift_done;
  } dp_stat_t;

  typedef struct packed {
    cmd_t             command;
    logic [IDX_W-1:0] index;
    logic [CRD_W-1:0] coord_x;
    logic [CRD_W-1:0] coord_y;
    logic [CRD_W-1:0] coord_z;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [CRD_W-1:0] point_x;
    logic [CRD_W-1:0] point_y;
    logic [CRD_W-1:0] point_z;
    logic [CNT_W-1:0] count;
  } rsp_t;

endpackage

// ===== hdl/pvb_if.sv =====
// Valid/ready channel interfaces for requests and results of the point vector buffer.
`timescale 1ns / 1ps

interface pvb_req_if;
  import pvb_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] index;
  logic [CRD_W-1:0] coord_x;
  logic [CRD_W-1:0] coord_y;
  logic [CRD_W-1:0] coord_z;

  modport source (output valid, command, index, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, command, index, coord_x, coord_y, coord_z, output ready);
endinterface

interface pvb_rsp_if;
  import pvb_pkg::*;

  logic             valid;
  logic             ready;
  logic [STS_W-1:0] status;
  logic [CRD_W-1:0] point_x;
  logic [CRD_W-1:0] point_y;
  logic [CRD_W-1:0] point_z;
  logic [CNT_W-1:0] count;

  modport source (output valid, status, point_x, point_y, point_z, count, input ready);
  modport sink (input valid, status, point_x, point_y, point_z, count, output ready);
endinterface

// ===== hdl/pvb_ctrl.sv =====
// Control state machine of the point vector buffer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pvb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pvb_pkg::dp_stat_t  stat,
  output pvb_pkg::dp_cmd_t   cmd
);
  import pvb_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = DP_NONE;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.need_shift) begin
          cmd.op    = DP_SHIFT_INIT;
          state_nxt = S_SHIFT;
        end else begin
          cmd.op    = DP_COMMIT;
          state_nxt = S_RESP;
        end
      end
      S_SHIFT: begin
        cmd.op = DP_SHIFT;
        if (stat.shift_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.op    = DP_COMMIT;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = DP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  // A new result only appears from the response state.
  `PVB_ASSERT_IMP(a_result_from_resp, $rose(out_valid_r), $past(state_r) == S_RESP, "result raised outside response state")
  // No shift may still be running once the controller is back to idle.
  `PVB_ASSERT_IMP(a_idle_shift_quiet, state_r == S_IDLE, stat.shift_done, "shift still active in idle")

endmodule

// ===== hdl/pvb_datapath.sv =====
// Point store, element counter, shift engine and result register of the point vector buffer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pvb_datapath #(
  parameter int CAPACITY    = 256,
  parameter int COORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pvb_pkg::dp_cmd_t  cmd,
  output pvb_pkg::dp_stat_t stat,
  input  pvb_pkg::req_t     req,
  output pvb_pkg::rsp_t     rsp
);
  import pvb_pkg::*;

  localparam int AW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CNTW > IDX_W) ? CNTW : IDX_W) + 1;
  localparam int PW   = 3 * COORD_WIDTH;

  logic [PW-1:0] mem [CAPACITY];

  req_t            req_r;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [PW-1:0]   rdata_r;
  logic            rd_act_r, rd_act_nxt;
  logic            wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]   rd_addr_r, rd_end_r, wr_addr_r;
  logic            dir_up_r;
  status_t         res_status_r;
  logic            res_read_r;
  rsp_t            rsp_r;

  logic [CMPW-1:0] idx_c, cnt_c;
  logic [CNTW-1:0] cnt_m1;
  logic [AW-1:0]   idx_a, cnt_a, last_a;
  logic            full;
  status_t         status_c;
  logic            ok;
  logic [PW-1:0]   point_in;
  logic            we, re;
  logic [AW-1:0]   wa, ra;
  logic [PW-1:0]   wd;

  assign idx_c  = CMPW'(req_r.index);
  assign cnt_c  = CMPW'(count_r);
  assign cnt_m1 = count_r - CNTW'(1);
  assign idx_a  = idx_c[AW-1:0];
  assign cnt_a  = count_r[AW-1:0];
  assign last_a = cnt_m1[AW-1:0];
  assign full   = (count_r == CNTW'(CAPACITY));

  assign point_in = {COORD_WIDTH'(req_r.coord_z), COORD_WIDTH'(req_r.coord_y),
                     COORD_WIDTH'(req_r.coord_x)};

  always_comb begin
    status_c = STAT_OK;
    unique case (req_r.command)
      CMD_PUSH:   if (full) status_c = STAT_FULL;
      CMD_POP:    if (count_r == '0) status_c = STAT_BOUNDS;
      CMD_GET,
      CMD_SET,
      CMD_REMOVE: if (idx_c >= cnt_c) status_c = STAT_BOUNDS;
      CMD_INSERT: begin
        if (idx_c > cnt_c) begin
          status_c = STAT_BOUNDS;
        end else if (full) begin
          status_c = STAT_FULL;
        end
      end
      default:    status_c = STAT_OK;
    endcase
  end

  assign ok = (status_c == STAT_OK);

  // Entries move only when the insert or remove point is not at the tail.
  assign stat.need_shift = ok &&
      (((req_r.command == CMD_INSERT) && (idx_c != cnt_c)) ||
       ((req_r.command == CMD_REMOVE) && ((idx_c + CMPW'(1)) != cnt_c)));
  assign stat.shift_done = !rd_act_r && !wr_pend_r;

  // Single write port and single read port of the store.
  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    re = 1'b0;
    ra = '0;
    if (cmd.op == DP_SHIFT) begin
      we = wr_pend_r;
      wa = wr_addr_r;
      wd = rdata_r;
      re = rd_act_r;
      ra = rd_addr_r;
    end else if (cmd.op == DP_COMMIT && ok) begin
      unique case (req_r.command)
        CMD_PUSH: begin
          we = 1'b1;
          wa = cnt_a;
          wd = point_in;
        end
        CMD_SET,
        CMD_INSERT: begin
          we = 1'b1;
          wa = idx_a;
          wd = point_in;
        end
        CMD_POP: begin
          re = 1'b1;
          ra = last_a;
        end
        CMD_GET: begin
          re = 1'b1;
          ra = idx_a;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_r <= mem[ra];
    end
  end

  always_comb begin
    count_nxt   = count_r;
    rd_act_nxt  = rd_act_r;
    wr_pend_nxt = wr_pend_r;
    if (cmd.op == DP_COMMIT && ok) begin
      unique case (req_r.command)
        CMD_PUSH,
        CMD_INSERT: count_nxt = count_r + CNTW'(1);
        CMD_POP,
        CMD_REMOVE: count_nxt = cnt_m1;
        CMD_CLEAR:  count_nxt = '0;
        default:    count_nxt = count_r;
      endcase
    end
    if (cmd.op == DP_SHIFT_INIT) begin
      rd_act_nxt  = 1'b1;
      wr_pend_nxt = 1'b0;
    end else if (cmd.op == DP_SHIFT) begin
      wr_pend_nxt = rd_act_r;
      if (rd_act_r && (rd_addr_r == rd_end_r)) begin
        rd_act_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_act_r  <= 1'b0;
      wr_pend_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      rd_act_r  <= rd_act_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD) begin
      req_r <= req;
    end
    if (cmd.op == DP_SHIFT_INIT) begin
      dir_up_r <= (req_r.command == CMD_INSERT);
      if (req_r.command == CMD_INSERT) begin
        rd_addr_r <= last_a;
        rd_end_r  <= idx_a;
      end else begin
        rd_addr_r <= idx_a + AW'(1);
        rd_end_r  <= last_a;
      end
    end else if (cmd.op == DP_SHIFT && rd_act_r) begin
      if (dir_up_r) begin
        wr_addr_r <= rd_addr_r + AW'(1);
        rd_addr_r <= rd_addr_r - AW'(1);
      end else begin
        wr_addr_r <= rd_addr_r - AW'(1);
        rd_addr_r <= rd_addr_r + AW'(1);
      end
    end
    if (cmd.op == DP_SHIFT_INIT || cmd.op == DP_COMMIT) begin
      res_status_r <= status_c;
      res_read_r   <= ok && ((req_r.command == CMD_POP) || (req_r.command == CMD_GET));
    end
    if (cmd.op == DP_RESULT) begin
      rsp_r.status <= res_status_r;
      rsp_r.count  <= CNT_W'(count_r);
      if (res_read_r) begin
        rsp_r.point_x <= CRD_W'(rdata_r[COORD_WIDTH-1:0]);
        rsp_r.point_y <= CRD_W'(rdata_r[2*COORD_WIDTH-1:COORD_WIDTH]);
        rsp_r.point_z <= CRD_W'(rdata_r[3*COORD_WIDTH-1:2*COORD_WIDTH]);
      end else begin
        rsp_r.point_x <= '0;
        rsp_r.point_y <= '0;
        rsp_r.point_z <= '0;
      end
    end
  end

  assign rsp = rsp_r;

  `PVB_ASSERT(a_count_in_range, count_r <= CNTW'(CAPACITY), "element count beyond capacity")
  `PVB_ASSERT_IMP(a_count_at_commit, $past(rst_n) && (count_r != $past(count_r)), $past(cmd.op) == DP_COMMIT, "count changed outside commit")
  `PVB_ASSERT_IMP(a_read_only_shift, rd_act_r, cmd.op == DP_SHIFT, "shift read pending outside shift")

endmodule

// ===== hdl/point_vector_buffer_unit.sv =====
// Point vector buffer top level: ordered store of 3D points with insert and remove.
// A request without a shift runs through execute and response; insert or remove that
// moves entries adds a shift phase and a finish step before the response.
// A new request is accepted only while the controller is idle, one at a time;
// the next request is taken while the last result still waits.
// Reset (rst_n low, synchronous) empties the store; entries stay undefined until written.
`timescale 1ns / 1ps

module point_vector_buffer_unit #(
  parameter int CAPACITY    = 256,
  parameter int COORD_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  pvb_req_if.sink   in_req,
  pvb_rsp_if.source out_rsp
);
  import pvb_pkg::*;

  // The controller sequences each request through execute, an optional
  // shift phase and a response step; the datapath holds the store and count.
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  req_t     req;
  rsp_t     rsp;

  // The request payload is captured by the datapath on the accepting edge.
  assign req.command = cmd_t'(in_req.command);
  assign req.index   = in_req.index;
  assign req.coord_x = in_req.coord_x;
  assign req.coord_y = in_req.coord_y;
  assign req.coord_z = in_req.coord_z;

  pvb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  pvb_datapath #(
    .CAPACITY    (CAPACITY),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_datapath (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (dp_cmd),
    .stat  (dp_stat),
    .req   (req),
    .rsp   (rsp)
  );

  // The result register stays stable until the sink takes it.
  assign out_rsp.status  = rsp.status;
  assign out_rsp.point_x = rsp.point_x;
  assign out_rsp.point_y = rsp.point_y;
  assign out_rsp.point_z = rsp.point_z;
  assign out_rsp.count   = rsp.count;

endmodule
